// ===== hw/rtl/sbsh_pkg.sv =====
`timescale 1ns / 1ps

package sbsh_pkg;

	// Input item and result item
	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// Item kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_FOLD,
		ST_EMIT
	} state_t;

	// Block positions and padding bytes
	localparam logic [5:0] LEN_POS       = 6'd56;
	localparam logic [5:0] LAST_POS      = 6'd63;
	localparam logic [5:0] LAST_ROUND    = 6'd63;
	localparam logic [2:0] LAST_WORD_IDX = 3'd7;
	localparam logic [7:0] PAD_MARK      = 8'h80;

	// Round constants
	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Initial chaining values
	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] v);
		return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] v);
		return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] v);
		return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] v);
		return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
	endfunction

endpackage

// ===== hw/rtl/sha256_byte_stream_hasher.sv =====
`timescale 1ns / 1ps

// SHA-256 hasher fed one message byte per input transfer.
// Input channel (in_valid/in_ready/in_item): kind 0 carries a data byte,
// kind 1 ends the message and requests the digest.
// Output channel (out_valid/out_ready/out_item): eight transfers per finish,
// digest words 0..7 in big-endian order, last_word set on word 7.
// The 64th byte of a block starts the shared round unit: 64 rounds, one per
// cycle, then a fold of the result into the chaining words.
// A finish feeds padding bytes through the same byte path, one per cycle:
// 64 - f bytes when f (bytes held) is at most 55, else 128 - f bytes,
// with one or two compressions, then the eight digest transfers.
// in_ready is high only when the sequencer is idle.
// If the receiver stalls, the current digest word is held until taken;
// nothing else moves meanwhile.
// Reset loads the initial chaining values and clears the byte counters;
// the block buffer needs no clearing since padding writes every byte.
module sha256_byte_stream_hasher
	import sbsh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	state_t state_q, state_d;

	logic [0:15][31:0] blk_q;
	logic [31:0]       chain_q [8];
	logic [31:0]       r_q [8];
	logic [5:0]        fill_q;
	logic [60:0]       msg_q;
	logic [63:0]       len_q;
	logic [5:0]        rnd_q;
	logic [2:0]        idx_q;
	logic              pad_q;
	logic              first_q;
	logic              len_ok_q;
	logic              final_q;

	logic              wr_en;
	logic [7:0]        wr_byte;
	logic [7:0]        pad_byte;
	logic              len_phase;
	logic [519:0]      blk_sh;
	logic [31:0]       t1, t2, w_new;

	// Padding byte source
	assign len_phase = !first_q && len_ok_q && (fill_q >= LEN_POS);
	always_comb begin
		priority if (first_q) begin
			pad_byte = PAD_MARK;
		end else if (len_phase) begin
			pad_byte = len_q[63:56];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign blk_sh = {blk_q, wr_byte};

	// Shared round unit and message schedule
	always_comb begin
		t1 = r_q[7] + big_sigma1(r_q[4]) + ((r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]))
			+ ROUND_K[rnd_q] + blk_q[0];
		t2 = big_sigma0(r_q[0])
			+ ((r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]));
		w_new = small_sigma1(blk_q[14]) + blk_q[9] + small_sigma0(blk_q[1]) + blk_q[0];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_item.kind == KIND_FINISH) begin
						state_d = ST_PAD;
					end else if (fill_q == LAST_POS) begin
						state_d = ST_COMP;
					end
				end
			end
			ST_PAD: begin
				if (fill_q == LAST_POS) begin
					state_d = ST_COMP;
				end
			end
			ST_COMP: begin
				if (rnd_q == LAST_ROUND) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				priority if (final_q) begin
					state_d = ST_EMIT;
				end else if (pad_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_ready && idx_q == LAST_WORD_IDX) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and byte write control
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		wr_en     = 1'b0;
		wr_byte   = in_item.data_byte;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				wr_en    = in_valid && (in_item.kind == KIND_DATA);
			end
			ST_PAD: begin
				wr_en   = 1'b1;
				wr_byte = pad_byte;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign out_item.digest_word = chain_q[idx_q];
	assign out_item.word_index  = idx_q;
	assign out_item.last_word   = (idx_q == LAST_WORD_IDX);

	// Payload registers
	always_ff @(posedge clk) begin
		if (wr_en) begin
			blk_q <= blk_sh[511:0];
			if (fill_q == LAST_POS) begin
				for (int i = 0; i < 8; i++) begin
					r_q[i] <= chain_q[i];
				end
			end
		end else if (state_q == ST_COMP) begin
			blk_q <= {blk_q[1:15], w_new};
			r_q[7] <= r_q[6];
			r_q[6] <= r_q[5];
			r_q[5] <= r_q[4];
			r_q[4] <= r_q[3] + t1;
			r_q[3] <= r_q[2];
			r_q[2] <= r_q[1];
			r_q[1] <= r_q[0];
			r_q[0] <= t1 + t2;
		end
		// length latched at finish, shifted out MSB first
		if (state_q == ST_IDLE && in_valid && in_item.kind == KIND_FINISH) begin
			len_q <= {msg_q, 3'b000};
		end else if (state_q == ST_PAD && len_phase) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

	// Control state and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			msg_q    <= '0;
			rnd_q    <= '0;
			idx_q    <= '0;
			pad_q    <= 1'b0;
			first_q  <= 1'b0;
			len_ok_q <= 1'b0;
			final_q  <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= INIT_HASH[i];
			end
		end else begin
			state_q <= state_d;

			// finish request opens the padding sequence
			if (state_q == ST_IDLE && in_valid) begin
				if (in_item.kind == KIND_FINISH) begin
					pad_q    <= 1'b1;
					first_q  <= 1'b1;
					len_ok_q <= 1'b0;
				end else begin
					msg_q <= msg_q + 61'd1;
				end
			end

			// padding flags; the length goes in once the marker leaves room
			// (marker in the last slot: the block-full branch below handles it)
			if (state_q == ST_PAD) begin
				first_q <= 1'b0;
				if (first_q && fill_q != LAST_POS) begin
					len_ok_q <= (fill_q < LEN_POS);
				end
			end

			// byte store and block-full kick-off
			if (wr_en) begin
				fill_q <= fill_q + 6'd1;
				if (fill_q == LAST_POS) begin
					rnd_q   <= '0;
					final_q <= pad_q && len_ok_q;
					if (pad_q) begin
						len_ok_q <= 1'b1;
					end
				end
			end

			if (state_q == ST_COMP) begin
				rnd_q <= rnd_q + 6'd1;
			end

			if (state_q == ST_FOLD) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + r_q[i];
				end
			end

			// digest transfer; the last one restarts the message
			if (state_q == ST_EMIT && out_ready) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == LAST_WORD_IDX) begin
					pad_q   <= 1'b0;
					final_q <= 1'b0;
					msg_q   <= '0;
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= INIT_HASH[i];
					end
				end
			end
		end
	end

endmodule
